### hdl/pct_pkg.sv
// Shared types, constants and helper functions for the pose calibration transform.
// Used by every module of the block; depends on nothing else.
package pct_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int IDX_W = 5;
   localparam int CW = 36;
   localparam int ZW = 28;
   localparam int AW = 30;

   localparam logic signed [ZW-1:0] ANG_PI = 28'sd52707179;
   localparam logic signed [AW-1:0] WRAP_PI = 30'sd52707179;
   localparam logic signed [AW-1:0] WRAP_TWO_PI = 30'sd105414358;
   localparam logic [29:0] MAG_GAIN = 30'd652032875;
   localparam logic signed [15:0] YAW_MAX = 16'sd25736;

   localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
      28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
      28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32,
      28'sd16, 28'sd8, 28'sd4, 28'sd2,
      28'sd1, 28'sd0, 28'sd0, 28'sd0,
      28'sd0, 28'sd0, 28'sd0, 28'sd0
   };

   typedef enum logic [2:0] {
      CSR_CALIB_ENABLED  = 3'd0,
      CSR_ROT_00         = 3'd1,
      CSR_ROT_01         = 3'd2,
      CSR_ROT_10         = 3'd3,
      CSR_ROT_11         = 3'd4,
      CSR_SHIFT_X        = 3'd5,
      CSR_SHIFT_Y        = 3'd6,
      CSR_HEADING_OFFSET = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [15:0] out_yaw;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_vel_z;
      logic signed [31:0] out_turn_rate;
      logic [31:0]        speed;
   } rsp_type;

   typedef struct packed {
      logic               calib_enabled;
      logic signed [15:0] rot_00;
      logic signed [15:0] rot_01;
      logic signed [15:0] rot_10;
      logic signed [15:0] rot_11;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [16:0] heading_offset;
   } cfg_type;

   // Data carried along the CORDIC cell chain: yaw and magnitude rotators side by
   // side, plus the already finished planar terms and the pass-through fields.
   typedef struct packed {
      logic               zero;
      logic signed [CW-1:0] yx;
      logic signed [CW-1:0] yy;
      logic signed [ZW-1:0] yz;
      logic signed [CW-1:0] mx;
      logic signed [CW-1:0] my;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] ovx;
      logic signed [31:0] ovy;
      logic signed [31:0] pz;
      logic signed [31:0] vz;
      logic signed [31:0] tr;
   } cell_type;

   // Sum of two rotation products, rounded half up by 14 bits.
   function automatic logic signed [34:0] rot_term(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
      logic signed [48:0] s;
      logic signed [48:0] r;
      s = 49'(a) + 49'(b);
      r = (s + 49'sd8192) >>> 14;
      return r[34:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/pose_calibration_transform.sv
// Top level of the pose calibration transform: register file, front end, CORDIC
// cell chain and back end. Depends on pct_pkg, pct_front, pct_cell and pct_back.
//
// The block takes one odometry sample per clock while req_stall is low and returns
// one result per sample, in order. Each sample passes the CORDIC chain, one cell per
// iteration, plus three front stages (products, planar sums, pre-rotation) and two
// back stages (heading wrap with gain products, then the result register). Each
// stage holds its item only while the stage after it is full and held, so empty
// slots fill up while a result waits. Configuration writes are always taken.
module pose_calibration_transform import pct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   cfg_type  cfg_ff;
   logic     chain_v    [CORDIC_STAGES+1];
   cell_type chain_d    [CORDIC_STAGES+1];
   logic     chain_hold [CORDIC_STAGES+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calib_enabled  <= 1'b0;
         cfg_ff.rot_00         <= 16'sd16384;
         cfg_ff.rot_01         <= '0;
         cfg_ff.rot_10         <= '0;
         cfg_ff.rot_11         <= 16'sd16384;
         cfg_ff.shift_x        <= '0;
         cfg_ff.shift_y        <= '0;
         cfg_ff.heading_offset <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CALIB_ENABLED:  cfg_ff.calib_enabled  <= csr_data[0];
            CSR_ROT_00:         cfg_ff.rot_00         <= csr_data[15:0];
            CSR_ROT_01:         cfg_ff.rot_01         <= csr_data[15:0];
            CSR_ROT_10:         cfg_ff.rot_10         <= csr_data[15:0];
            CSR_ROT_11:         cfg_ff.rot_11         <= csr_data[15:0];
            CSR_SHIFT_X:        cfg_ff.shift_x        <= csr_data;
            CSR_SHIFT_Y:        cfg_ff.shift_y        <= csr_data;
            CSR_HEADING_OFFSET: cfg_ff.heading_offset <= csr_data[16:0];
            default: begin
            end
         endcase
      end
   end

   pct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .v_out     (chain_v[0]),
      .d_out     (chain_d[0]),
      .hold_dn   (chain_hold[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      pct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IDX_W'(g)),
         .v_in      (chain_v[g]),
         .d_in      (chain_d[g]),
         .hold_up   (chain_hold[g]),
         .v_out     (chain_v[g+1]),
         .d_out     (chain_d[g+1]),
         .hold_dn   (chain_hold[g+1])
      );
   end

   pct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .v_in      (chain_v[CORDIC_STAGES]),
      .d_in      (chain_d[CORDIC_STAGES]),
      .cfg       (cfg_ff),
      .hold_up   (chain_hold[CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/pct_front.sv
// Front end: rotation products, planar transform with saturation, quaternion yaw
// terms and CORDIC pre-rotation. Depends on pct_pkg.
module pct_front import pct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  cfg_type  cfg,
   output logic     v_out,
   output cell_type d_out,
   input  logic     hold_dn
);

   logic               s1_v_ff;
   logic signed [47:0] pp_ff [8];
   logic signed [31:0] qp_ff [4];
   req_type            s1_d_ff;

   logic               s2_v_ff;
   logic signed [31:0] s2_ox_ff, s2_oy_ff, s2_ovx_ff, s2_ovy_ff;
   logic signed [31:0] s2_pz_ff, s2_vz_ff, s2_tr_ff;
   logic signed [33:0] s2_num_ff, s2_den_ff;

   logic               v3_ff;
   cell_type           d3_ff;

   logic hold1, hold2, hold3;

   logic signed [34:0] t_ox, t_oy, t_ovx, t_ovy;
   logic signed [31:0] ox_in, oy_in, ovx_in, ovy_in;
   logic signed [33:0] num_in, den_in;
   cell_type           d3_in;

   assign hold3 = v3_ff && hold_dn;
   assign hold2 = s2_v_ff && hold3;
   assign hold1 = s1_v_ff && hold2;
   assign req_stall = hold1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         if (!hold1) s1_v_ff <= req_valid;
         if (!hold2) s2_v_ff <= s1_v_ff;
         if (!hold3) v3_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1 && req_valid) begin
         pp_ff[0] <= cfg.rot_00 * req_data.pos_x;
         pp_ff[1] <= cfg.rot_01 * req_data.pos_y;
         pp_ff[2] <= cfg.rot_10 * req_data.pos_x;
         pp_ff[3] <= cfg.rot_11 * req_data.pos_y;
         pp_ff[4] <= cfg.rot_00 * req_data.vel_x;
         pp_ff[5] <= cfg.rot_01 * req_data.vel_y;
         pp_ff[6] <= cfg.rot_10 * req_data.vel_x;
         pp_ff[7] <= cfg.rot_11 * req_data.vel_y;
         qp_ff[0] <= req_data.quat_w * req_data.quat_z;
         qp_ff[1] <= req_data.quat_x * req_data.quat_y;
         qp_ff[2] <= req_data.quat_y * req_data.quat_y;
         qp_ff[3] <= req_data.quat_z * req_data.quat_z;
         s1_d_ff  <= req_data;
      end
   end

   always_comb begin
      t_ox  = rot_term(pp_ff[0], pp_ff[1]);
      t_oy  = rot_term(pp_ff[2], pp_ff[3]);
      t_ovx = rot_term(pp_ff[4], pp_ff[5]);
      t_ovy = rot_term(pp_ff[6], pp_ff[7]);
      if (cfg.calib_enabled) begin
         ox_in  = sat32(36'(t_ox) + 36'(cfg.shift_x));
         oy_in  = sat32(36'(t_oy) + 36'(cfg.shift_y));
         ovx_in = sat32(36'(t_ovx));
         ovy_in = sat32(36'(t_ovy));
      end else begin
         ox_in  = s1_d_ff.pos_x;
         oy_in  = s1_d_ff.pos_y;
         ovx_in = s1_d_ff.vel_x;
         ovy_in = s1_d_ff.vel_y;
      end
      num_in = (34'(qp_ff[0]) + 34'(qp_ff[1])) <<< 1;
      den_in = 34'sd268435456 - ((34'(qp_ff[2]) + 34'(qp_ff[3])) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (!hold2 && s1_v_ff) begin
         s2_ox_ff  <= ox_in;
         s2_oy_ff  <= oy_in;
         s2_ovx_ff <= ovx_in;
         s2_ovy_ff <= ovy_in;
         s2_pz_ff  <= s1_d_ff.pos_z;
         s2_vz_ff  <= s1_d_ff.vel_z;
         s2_tr_ff  <= s1_d_ff.turn_rate;
         s2_num_ff <= num_in;
         s2_den_ff <= den_in;
      end
   end

   // A vector in the left half plane is turned by pi first so the cells converge.
   always_comb begin
      d3_in.zero = (s2_num_ff == 34'sd0) && (s2_den_ff == 34'sd0);
      if (s2_den_ff < 34'sd0) begin
         d3_in.yx = -CW'(s2_den_ff);
         d3_in.yy = -CW'(s2_num_ff);
         d3_in.yz = (s2_num_ff >= 34'sd0) ? ANG_PI : -ANG_PI;
      end else begin
         d3_in.yx = CW'(s2_den_ff);
         d3_in.yy = CW'(s2_num_ff);
         d3_in.yz = '0;
      end
      d3_in.mx  = (s2_ovx_ff < 32'sd0) ? -CW'(s2_ovx_ff) : CW'(s2_ovx_ff);
      d3_in.my  = (s2_ovy_ff < 32'sd0) ? -CW'(s2_ovy_ff) : CW'(s2_ovy_ff);
      d3_in.ox  = s2_ox_ff;
      d3_in.oy  = s2_oy_ff;
      d3_in.ovx = s2_ovx_ff;
      d3_in.ovy = s2_ovy_ff;
      d3_in.pz  = s2_pz_ff;
      d3_in.vz  = s2_vz_ff;
      d3_in.tr  = s2_tr_ff;
   end

   always_ff @(posedge clock) begin
      if (!hold3 && s2_v_ff) begin
         d3_ff <= d3_in;
      end
   end

   assign v_out = v3_ff;
   assign d_out = d3_ff;

endmodule

### hdl/pct_cell.sv
// One CORDIC vectoring cell: a single iteration of the yaw and magnitude rotators.
// Depends on pct_pkg.
module pct_cell import pct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] stage_idx,
   input  logic             v_in,
   input  cell_type         d_in,
   output logic             hold_up,
   output logic             v_out,
   output cell_type         d_out,
   input  logic             hold_dn
);

   logic     v_ff;
   cell_type d_ff;
   cell_type d_next;

   assign hold_up = v_ff && hold_dn;

   always_comb begin
      d_next = d_in;
      if (d_in.yy >= 0) begin
         d_next.yx = d_in.yx + (d_in.yy >>> stage_idx);
         d_next.yy = d_in.yy - (d_in.yx >>> stage_idx);
         d_next.yz = d_in.yz + ATAN_TAB[stage_idx];
      end else begin
         d_next.yx = d_in.yx - (d_in.yy >>> stage_idx);
         d_next.yy = d_in.yy + (d_in.yx >>> stage_idx);
         d_next.yz = d_in.yz - ATAN_TAB[stage_idx];
      end
      if (d_in.my >= 0) begin
         d_next.mx = d_in.mx + (d_in.my >>> stage_idx);
         d_next.my = d_in.my - (d_in.mx >>> stage_idx);
      end else begin
         d_next.mx = d_in.mx - (d_in.my >>> stage_idx);
         d_next.my = d_in.my + (d_in.mx >>> stage_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (!hold_up) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_up && v_in) begin
         d_ff <= d_next;
      end
   end

   assign v_out = v_ff;
   assign d_out = d_ff;

endmodule

### hdl/pct_back.sv
// Back end: heading offset, wrap and rounding; magnitude gain in two partial
// products; result register. Depends on pct_pkg.
module pct_back import pct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     v_in,
   input  cell_type d_in,
   input  cfg_type  cfg,
   output logic     hold_up,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic               b1_v_ff;
   logic signed [15:0] b1_yaw_ff;
   logic [46:0]        b1_plo_ff, b1_phi_ff;
   cell_type           b1_d_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic hold_b1, hold_b2;

   logic signed [AW-1:0] ang0, ang1, ang2, ang3, ang4, rnd;
   logic signed [15:0]   yaw_in;
   logic [64:0]          msum;
   logic [34:0]          mres;
   logic [31:0]          speed_in;

   assign hold_b2 = rsp_valid_ff && rsp_stall;
   assign hold_b1 = b1_v_ff && hold_b2;
   assign hold_up = hold_b1;

   always_comb begin
      ang0 = d_in.zero ? '0 : AW'(d_in.yz);
      if (cfg.calib_enabled) begin
         ang0 = ang0 + (AW'(cfg.heading_offset) <<< 11);
      end
      ang1 = (ang0 > WRAP_PI) ? ang0 - WRAP_TWO_PI : ang0;
      ang2 = (ang1 > WRAP_PI) ? ang1 - WRAP_TWO_PI : ang1;
      ang3 = (ang2 <= -WRAP_PI) ? ang2 + WRAP_TWO_PI : ang2;
      ang4 = (ang3 <= -WRAP_PI) ? ang3 + WRAP_TWO_PI : ang3;
      rnd  = (ang4 + AW'(1024)) >>> 11;
      if (rnd > AW'(YAW_MAX)) begin
         yaw_in = YAW_MAX;
      end else if (rnd < -AW'(YAW_MAX)) begin
         yaw_in = -YAW_MAX;
      end else begin
         yaw_in = rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!hold_b1) b1_v_ff <= v_in;
         if (!hold_b2) rsp_valid_ff <= b1_v_ff;
      end
   end

   // The magnitude is non-negative and below 2^34, so it splits into two
   // 17-bit halves for the gain multiply.
   always_ff @(posedge clock) begin
      if (!hold_b1 && v_in) begin
         b1_yaw_ff <= yaw_in;
         b1_plo_ff <= 47'(d_in.mx[16:0]) * 47'(MAG_GAIN);
         b1_phi_ff <= 47'(d_in.mx[33:17]) * 47'(MAG_GAIN);
         b1_d_ff   <= d_in;
      end
   end

   always_comb begin
      msum = {1'b0, b1_phi_ff, 17'd0} + 65'(b1_plo_ff) + 65'(1 << 29);
      mres = msum[64:30];
      speed_in = (mres > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : mres[31:0];
   end

   always_ff @(posedge clock) begin
      if (!hold_b2 && b1_v_ff) begin
         rsp_data_ff.out_x         <= b1_d_ff.ox;
         rsp_data_ff.out_y         <= b1_d_ff.oy;
         rsp_data_ff.out_z         <= b1_d_ff.pz;
         rsp_data_ff.out_yaw       <= b1_yaw_ff;
         rsp_data_ff.out_vel_x     <= b1_d_ff.ovx;
         rsp_data_ff.out_vel_y     <= b1_d_ff.ovy;
         rsp_data_ff.out_vel_z     <= b1_d_ff.vz;
         rsp_data_ff.out_turn_rate <= b1_d_ff.tr;
         rsp_data_ff.speed         <= speed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.out_yaw <= YAW_MAX) && (rsp_data_ff.out_yaw >= -YAW_MAX))
      else $error("heading outside the wrapped range");

   a_b1_kept: assert property (@(posedge clock) disable iff (reset)
      hold_b1 |=> b1_v_ff && $stable(b1_yaw_ff))
      else $error("back stage lost an item while the output was stalled");

   a_out_kept: assert property (@(posedge clock) disable iff (reset)
      hold_b2 |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result register changed while stalled");

endmodule
